>>> rtl/pfa_pkg.sv
// Shared types, constants and the control store for the page frame allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int MAX_FRAMES = 1024;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int MAX_COUNT  = 64;
    localparam int COUNT_W    = 7;
    localparam int CFG_W      = 11;

    localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(MAX_FRAMES);
    localparam logic [FRAME_W-1:0] TOTAL_SAT  = FRAME_W'(MAX_FRAMES - 1);

    // Command codes.
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_REBUILD = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_SHORT = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [COUNT_W-1:0] count;
        logic [FRAME_W-1:0] free_frame;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic [FRAME_W-1:0] alloc_frame;
        logic               last;
        logic [FRAME_W-1:0] frames_free;
    } t_res;

    // Microprogram addresses.
    typedef enum logic [3:0] {
        S_IDLE  = 4'd0,
        S_ACHK  = 4'd1,
        S_ARD   = 4'd2,
        S_APOP  = 4'd3,
        S_AREJ  = 4'd4,
        S_FCHK  = 4'd5,
        S_FPUSH = 4'd6,
        S_FREJ  = 4'd7,
        S_RINIT = 4'd8,
        S_RFILL = 4'd9,
        S_RDONE = 4'd10
    } t_step;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_DISPATCH,
        C_ABAD,
        C_FBAD,
        C_CNT_MORE,
        C_FILL_MORE
    } t_cond;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_READ,
        DP_POP,
        DP_PUSH,
        DP_FINIT,
        DP_FILL,
        DP_FDONE
    } t_dp_op;

    typedef enum logic [2:0] {
        E_NONE,
        E_POP,
        E_OK,
        E_AREJ,
        E_RANGE
    } t_emit;

    typedef struct packed {
        t_cond  cond;
        t_step  target;
        logic   done;
        t_dp_op dp;
        t_emit  emit;
    } t_uword;

    typedef struct packed {
        logic abad;
        logic fbad;
        logic cnt_more;
        logic fill_more;
    } t_flags;

    typedef struct packed {
        logic               we;
        logic [FRAME_W-1:0] waddr;
        logic [FRAME_W-1:0] wdata;
        logic               re;
        logic [FRAME_W-1:0] raddr;
    } t_mem_req;

    // Control store. Idle dispatches by op; a taken jump goes to target;
    // otherwise done returns to idle and a clear done goes to the next address.
    function automatic t_uword uc_rom(input t_step step);
        t_uword w;
        w = '{cond: C_NEVER, target: S_IDLE, done: 1'b1, dp: DP_NOP, emit: E_NONE};
        case (step)
            S_IDLE:  w = '{C_DISPATCH,  S_IDLE,  1'b0, DP_NOP,   E_NONE};
            S_ACHK:  w = '{C_ABAD,      S_AREJ,  1'b0, DP_NOP,   E_NONE};
            S_ARD:   w = '{C_NEVER,     S_IDLE,  1'b0, DP_READ,  E_NONE};
            S_APOP:  w = '{C_CNT_MORE,  S_ARD,   1'b1, DP_POP,   E_POP};
            S_AREJ:  w = '{C_NEVER,     S_IDLE,  1'b1, DP_NOP,   E_AREJ};
            S_FCHK:  w = '{C_FBAD,      S_FREJ,  1'b0, DP_NOP,   E_NONE};
            S_FPUSH: w = '{C_NEVER,     S_IDLE,  1'b1, DP_PUSH,  E_OK};
            S_FREJ:  w = '{C_NEVER,     S_IDLE,  1'b1, DP_NOP,   E_RANGE};
            S_RINIT: w = '{C_NEVER,     S_IDLE,  1'b0, DP_FINIT, E_NONE};
            S_RFILL: w = '{C_FILL_MORE, S_RFILL, 1'b0, DP_FILL,  E_NONE};
            S_RDONE: w = '{C_NEVER,     S_IDLE,  1'b1, DP_FDONE, E_OK};
            default: w = '{C_NEVER,     S_IDLE,  1'b1, DP_NOP,   E_NONE};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/pfa_link_mem.sv
// Link memory of the free list: one next-frame entry per page frame.
// One write port and one registered read port. Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_link_mem
    import pfa_pkg::*;
(
    input  logic               i_clk,
    input  t_mem_req           i_req,
    output logic [FRAME_W-1:0] o_rdata
);

    logic [FRAME_W-1:0] r_mem [MAX_FRAMES];
    logic [FRAME_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/pfa_useq.sv
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on pfa_pkg for the control word, the flags and the program.
`timescale 1ns / 1ps

module pfa_useq
    import pfa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  t_flags     i_flags,
    output t_uword     o_uw,
    output logic       o_accept,
    output logic       o_busy
);

    t_step  r_upc;
    t_step  n_upc;
    t_uword uw;
    logic   taken;

    assign uw       = uc_rom(r_upc);
    assign o_uw     = uw;
    assign o_busy   = (r_upc != S_IDLE);
    assign o_accept = i_start && (r_upc == S_IDLE);

    always_comb begin
        case (uw.cond)
            C_ALWAYS:    taken = 1'b1;
            C_ABAD:      taken = i_flags.abad;
            C_FBAD:      taken = i_flags.fbad;
            C_CNT_MORE:  taken = i_flags.cnt_more;
            C_FILL_MORE: taken = i_flags.fill_more;
            default:     taken = 1'b0;
        endcase

        if (uw.cond == C_DISPATCH) begin
            n_upc = S_IDLE;
            if (o_accept) begin
                case (i_op)
                    OP_ALLOC:   n_upc = S_ACHK;
                    OP_FREE:    n_upc = S_FCHK;
                    OP_REBUILD: n_upc = S_RINIT;
                    default:    n_upc = S_IDLE;
                endcase
            end
        end else if (taken) begin
            n_upc = uw.target;
        end else if (uw.done) begin
            n_upc = S_IDLE;
        end else begin
            n_upc = t_step'(r_upc + 4'd1);
        end
    end

    // Reset enters the rebuild routine so the list is built before first use.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_RINIT;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

>>> rtl/pfa_dpath.sv
// Datapath of the allocator: list head, free total, command and sweep
// registers, the size register and the result register. Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_dpath
    import pfa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  t_cmd               i_cmd,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_wdata,
    input  t_uword             i_uw,
    input  logic [FRAME_W-1:0] i_rdata,
    output t_mem_req           o_mem,
    output t_flags             o_flags,
    output logic               o_res_strobe,
    output t_res               o_res
);

    logic [CFG_W-1:0]   r_cfg_total;
    t_cmd               r_cmd;
    logic [COUNT_W-1:0] r_cnt,   n_cnt;
    logic [FRAME_W-1:0] r_head,  n_head;
    logic [FRAME_W-1:0] r_total, n_total;
    logic [FRAME_W-1:0] r_idx,   n_idx;
    logic [FRAME_W-1:0] r_tm1,   n_tm1;
    logic               r_rd_zero, n_rd_zero;
    logic               r_quiet, n_quiet;
    logic               r_strobe, n_strobe;
    t_res               r_res, n_res;

    logic [CFG_W-1:0]   eff_total;
    logic [FRAME_W-1:0] link;
    logic [1:0]         arej_status;

    always_comb begin
        if (r_cfg_total < CFG_W'(2)) begin
            eff_total = CFG_W'(2);
        end else if (r_cfg_total > CFG_W'(MAX_FRAMES)) begin
            eff_total = CFG_W'(MAX_FRAMES);
        end else begin
            eff_total = r_cfg_total;
        end
    end

    // Frame zero is the end mark; following it yields zero again.
    assign link = r_rd_zero ? '0 : i_rdata;

    always_comb begin
        if (r_cmd.count > COUNT_W'(MAX_COUNT)) begin
            arej_status = ST_RANGE;
        end else if ({3'b000, r_cmd.count} > r_total) begin
            arej_status = ST_SHORT;
        end else begin
            arej_status = ST_OK;
        end
    end

    assign o_flags.abad      = (r_cmd.count > COUNT_W'(MAX_COUNT))
                            || ({3'b000, r_cmd.count} > r_total)
                            || (r_cmd.count == '0);
    assign o_flags.fbad      = (r_cmd.free_frame == '0)
                            || ({1'b0, r_cmd.free_frame} >= eff_total);
    assign o_flags.cnt_more  = (r_cnt != COUNT_W'(1));
    assign o_flags.fill_more = (r_idx != r_tm1);

    always_comb begin
        n_cnt     = r_cnt;
        n_head    = r_head;
        n_total   = r_total;
        n_idx     = r_idx;
        n_tm1     = r_tm1;
        n_rd_zero = r_rd_zero;
        n_quiet   = r_quiet;
        o_mem     = '{we: 1'b0, waddr: r_cmd.free_frame, wdata: r_head,
                      re: 1'b0, raddr: r_head};

        if (i_accept) begin
            n_cnt = i_cmd.count;
        end

        case (i_uw.dp)
            DP_READ: begin
                o_mem.re  = 1'b1;
                n_rd_zero = (r_head == '0);
            end
            DP_POP: begin
                n_head  = link;
                n_total = r_total - FRAME_W'(1);
                n_cnt   = r_cnt - COUNT_W'(1);
            end
            DP_PUSH: begin
                o_mem.we = 1'b1;
                n_head   = r_cmd.free_frame;
                if (r_total != TOTAL_SAT) begin
                    n_total = r_total + FRAME_W'(1);
                end
            end
            DP_FINIT: begin
                n_idx = FRAME_W'(1);
                n_tm1 = FRAME_W'(eff_total - CFG_W'(1));
            end
            DP_FILL: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_idx;
                o_mem.wdata = (r_idx == r_tm1) ? '0 : r_idx + FRAME_W'(1);
                n_idx       = r_idx + FRAME_W'(1);
            end
            DP_FDONE: begin
                n_head  = FRAME_W'(1);
                n_total = r_tm1;
                n_quiet = 1'b0;
            end
            default: begin
            end
        endcase

        n_res = '{status: ST_OK, alloc_frame: '0, last: 1'b1, frames_free: n_total};
        n_strobe = 1'b1;
        case (i_uw.emit)
            E_POP: begin
                n_res.alloc_frame = r_head;
                n_res.last        = (r_cnt == COUNT_W'(1));
            end
            E_OK: begin
                // The rebuild that follows reset delivers no item.
                n_strobe = !r_quiet;
            end
            E_AREJ:  n_res.status = arej_status;
            E_RANGE: n_res.status = ST_RANGE;
            default: n_strobe = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_total <= CFG_RESET;
            r_quiet     <= 1'b1;
            r_strobe    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg_total <= i_cfg_wdata;
            end
            r_quiet  <= n_quiet;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_cmd <= i_cmd;
        end
        r_cnt     <= n_cnt;
        r_head    <= n_head;
        r_total   <= n_total;
        r_idx     <= n_idx;
        r_tm1     <= n_tm1;
        r_rd_zero <= n_rd_zero;
        r_res     <= n_res;
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

>>> rtl/page_frame_free_list_allocator.sv
// Top level of the page frame allocator: sequencer, datapath and link memory.
// Depends on pfa_pkg, pfa_useq, pfa_dpath and pfa_link_mem.
`timescale 1ns / 1ps

// Usage. An item (op, count, free_frame on i_cmd) is taken at a clock edge
// where start is high and busy is low. Each result appears on o_res for one
// cycle with o_res_strobe high; the receiver cannot hold results off, and
// none is ever waiting, so nothing stalls on the output side.
// Steps of each item from the accepting edge, with busy high throughout:
//   allocate of n frames: a check, then per frame a link memory read and
//   a pop that gives that frame's result.
//   rejected allocate or free, and accepted free: a check and a result step.
//   rebuild: an init step, a sweep of T-1 link entries, one a cycle, and a
//   done step that gives one result at the end.
// Busy drops in the cycle the final result is shown, so a new item may be
// taken then. i_cfg_we / i_cfg_wdata write total_frames; the user is to do
// so only while idle, as the block itself does not enforce it. The new
// size is used by the range check at once and by the list at the next
// rebuild. Reset is synchronous and runs a rebuild of 1023 entries for the
// reset size, with busy high throughout and no result given.

module page_frame_free_list_allocator
    import pfa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd             i_cmd,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_wdata,
    output logic             o_res_strobe,
    output t_res             o_res
);

    t_uword             uw;
    t_flags             flags;
    t_mem_req           mem_req;
    logic [FRAME_W-1:0] rdata;
    logic               accept;

    pfa_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_op     (i_cmd.op),
        .i_flags  (flags),
        .o_uw     (uw),
        .o_accept (accept),
        .o_busy   (busy)
    );

    pfa_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_uw         (uw),
        .i_rdata      (rdata),
        .o_mem        (mem_req),
        .o_flags      (flags),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    pfa_link_mem u_link_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for the page frame allocator: directed and random items
// against a cycle-free predictor of the free list. Depends on pfa_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import pfa_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         QUIET_LIMIT = 5000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_cmd             i_cmd = '0;
    logic             i_cfg_we = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata = '0;
    logic             o_res_strobe;
    t_res             o_res;

    // Predicted allocator state.
    logic [FRAME_W-1:0] link_mem [MAX_FRAMES];
    logic [FRAME_W-1:0] list_head;
    logic [FRAME_W-1:0] frames_left;
    logic [CFG_W-1:0]   frame_total_cfg;

    t_res               expected_results [$];
    logic [FRAME_W-1:0] loaned_frames [$];
    int unsigned        mismatches = 0;
    int unsigned        quiet_cycles = 0;
    bit                 no_gaps = 1'b0;

    page_frame_free_list_allocator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int unsigned usable_frames();
        if (frame_total_cfg < 2) return 2;
        if (frame_total_cfg > MAX_FRAMES) return MAX_FRAMES;
        return 32'(frame_total_cfg);
    endfunction

    function automatic t_cmd make_cmd(input logic [1:0] op, input int unsigned count,
                                      input int unsigned frame);
        t_cmd c;
        c.op         = op;
        c.count      = COUNT_W'(count);
        c.free_frame = FRAME_W'(frame);
        return c;
    endfunction

    task automatic relink_all_frames();
        int unsigned t;
        t = usable_frames();
        for (int unsigned i = 1; i < t; i++)
            link_mem[FRAME_W'(i)] = (i + 1 < t) ? FRAME_W'(i + 1) : '0;
        list_head   = FRAME_W'(1);
        frames_left = FRAME_W'(t - 1);
        loaned_frames.delete();
    endtask

    task automatic queue_result(input logic [1:0] status, input logic [FRAME_W-1:0] frame,
                                input logic last);
        t_res r;
        r.status      = status;
        r.alloc_frame = frame;
        r.last        = last;
        r.frames_free = frames_left;
        expected_results = {expected_results, r};
    endtask

    // Applies one accepted item to the predicted state and queues its results.
    task automatic predict_outcome(input t_cmd c);
        logic [FRAME_W-1:0] got;
        case (c.op)
            OP_ALLOC: begin
                if (c.count > MAX_COUNT) begin
                    queue_result(ST_RANGE, '0, 1'b1);
                end else if (c.count > frames_left) begin
                    queue_result(ST_SHORT, '0, 1'b1);
                end else if (c.count == 0) begin
                    queue_result(ST_OK, '0, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < c.count; i++) begin
                        got = list_head;
                        list_head = link_mem[got];
                        frames_left = frames_left - 1'b1;
                        loaned_frames = {loaned_frames, got};
                        queue_result(ST_OK, got, i + 1 == c.count);
                    end
                end
            end
            OP_FREE: begin
                if (c.free_frame == 0 || c.free_frame >= usable_frames()) begin
                    queue_result(ST_RANGE, '0, 1'b1);
                end else begin
                    // A frame that is already free is pushed again; the total saturates.
                    link_mem[c.free_frame] = list_head;
                    list_head = c.free_frame;
                    if (frames_left < TOTAL_SAT)
                        frames_left = frames_left + 1'b1;
                    queue_result(ST_OK, '0, 1'b1);
                end
            end
            OP_REBUILD: begin
                relink_all_frames();
                queue_result(ST_OK, '0, 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic log_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
        $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Leaves start high after acceptance so back-to-back items need no extra edge.
    task automatic send_item(input t_cmd c);
        while (!no_gaps && $urandom_range(99) < 19) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_outcome(c);
    endtask

    task automatic write_frame_total(input logic [CFG_W-1:0] value);
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        // An ignored item gives no result, so the queue alone cannot show that all is done; busy is waited out too.
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        frame_total_cfg = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_alloc_basic();
        send_item(make_cmd(OP_ALLOC, 1, 0));
        send_item(make_cmd(OP_ALLOC, MAX_COUNT, 1023));
        send_item(make_cmd(OP_ALLOC, 0, 0));
        send_item(make_cmd(OP_ALLOC, MAX_COUNT + 1, 0));
        send_item(make_cmd(OP_ALLOC, 127, 1023));
    endtask

    task automatic test_free_cases();
        send_item(make_cmd(OP_FREE, 0, 0));
        send_item(make_cmd(OP_FREE, 127, 1023));
        send_item(make_cmd(OP_FREE, 0, 1));
        send_item(make_cmd(OP_FREE, 0, 40));
        send_item(make_cmd(OP_ALLOC, 2, 0));
    endtask

    task automatic test_unused_op();
        send_item(make_cmd(OP_UNUSED, 127, 1023));
        send_item(make_cmd(OP_UNUSED, 0, 0));
    endtask

    task automatic test_frame_total_limits();
        // Smallest list: one usable frame, so a second request runs short.
        write_frame_total(CFG_W'(2));
        send_item(make_cmd(OP_REBUILD, 0, 0));
        send_item(make_cmd(OP_ALLOC, 1, 0));
        send_item(make_cmd(OP_ALLOC, 1, 0));
        send_item(make_cmd(OP_FREE, 0, 1));
        send_item(make_cmd(OP_FREE, 0, 2));
        write_frame_total(CFG_W'(0));
        send_item(make_cmd(OP_FREE, 0, 1));
        write_frame_total(CFG_W'(1));
        send_item(make_cmd(OP_ALLOC, 2, 0));
        // The range check follows a new size before any rebuild.
        write_frame_total(CFG_W'(3));
        send_item(make_cmd(OP_FREE, 0, 2));
        write_frame_total(CFG_W'(2047));
        send_item(make_cmd(OP_REBUILD, 0, 0));
        send_item(make_cmd(OP_FREE, 0, 5));
        send_item(make_cmd(OP_ALLOC, 1, 0));
        write_frame_total(CFG_W'(1025));
        send_item(make_cmd(OP_FREE, 0, 1023));
    endtask

    task automatic test_random_traffic(input int unsigned n_items,
                                       input logic [CFG_W-1:0] total, input bit steady);
        t_cmd        c;
        int unsigned sent;
        int unsigned pick;
        int unsigned idx;
        write_frame_total(total);
        no_gaps = steady;
        send_item(make_cmd(OP_REBUILD, 0, 0));
        sent = 1;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            c = make_cmd(OP_ALLOC, $urandom_range(127), $urandom_range(1023));
            if (pick < 48) begin
                pick = $urandom_range(99);
                if (pick < 4)
                    c.count = '0;
                else if (pick < 10)
                    c.count = COUNT_W'($urandom_range(127, MAX_COUNT + 1));
                else if (pick < 25)
                    c.count = COUNT_W'($urandom_range(MAX_COUNT, 17));
                else
                    c.count = COUNT_W'($urandom_range(16, 1));
            end else if (pick < 92) begin
                c.op = OP_FREE;
                // Mostly hand back frames that are out; the rest is noise.
                if (loaned_frames.size() != 0 && $urandom_range(99) < 70) begin
                    idx = $urandom_range(loaned_frames.size() - 1);
                    c.free_frame = loaned_frames[idx];
                    loaned_frames.delete(idx);
                end
            end else if (pick < 96) begin
                c.op = OP_REBUILD;
            end else begin
                c.op = OP_UNUSED;
            end
            send_item(c);
            if (c.op != OP_UNUSED)
                sent++;
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            if (expected_results.size() == 0) begin
                log_mismatch("result with nothing pending, frame",
                             32'(o_res.alloc_frame), 0);
            end else begin
                want = expected_results.pop_front();
                if (o_res.status !== want.status)
                    log_mismatch("status", 32'(o_res.status), 32'(want.status));
                if (o_res.alloc_frame !== want.alloc_frame)
                    log_mismatch("alloc_frame", 32'(o_res.alloc_frame),
                                 32'(want.alloc_frame));
                if (o_res.last !== want.last)
                    log_mismatch("last", 32'(o_res.last), 32'(want.last));
                if (o_res.frames_free !== want.frames_free)
                    log_mismatch("frames_free", 32'(o_res.frames_free),
                                 32'(want.frames_free));
            end
        end
    end

    // Counts cycles in which no item, result or register write moves.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < MAX_FRAMES; i++)
            link_mem[FRAME_W'(i)] = '0;
        frame_total_cfg = CFG_RESET;
        relink_all_frames();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_alloc_basic();
        test_free_cases();
        test_unused_op();
        test_frame_total_limits();
        test_random_traffic(95, CFG_W'(1024), 1'b0);
        test_random_traffic(100, CFG_W'(24), 1'b0);
        test_random_traffic(100, CFG_W'($urandom_range(300, 2)), 1'b1);
        test_random_traffic(80, CFG_W'(2047), 1'b0);

        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> page_frame_free_list_allocator.f
rtl/pfa_pkg.sv
rtl/pfa_link_mem.sv
rtl/pfa_useq.sv
rtl/pfa_dpath.sv
rtl/page_frame_free_list_allocator.sv
tb/sv/tb_top.sv
